### rtl/dllm_pkg.sv
`default_nettype none

package dllm_pkg;

  // widths of the item fields
  localparam int unsigned CMD_W  = 4;
  localparam int unsigned LIST_W = 2;
  localparam int unsigned NODE_W = 6;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 4'd0,
    CMD_ADD_TAIL = 4'd1,
    CMD_ADD_HEAD = 4'd2,
    CMD_INSERT   = 4'd3,
    CMD_REM_HEAD = 4'd4,
    CMD_REMOVE   = 4'd5,
    CMD_HEAD     = 4'd6,
    CMD_TAIL     = 4'd7,
    CMD_SUCC     = 4'd8,
    CMD_PRED     = 4'd9
  } cmd_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LINK,
    ST_UNLINK,
    ST_DETACH,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

### rtl/dllm_in_if.sv
`default_nettype none

interface dllm_in_if;
  logic                         valid;
  logic                         ready;
  logic [dllm_pkg::CMD_W-1:0]   cmd;
  logic [dllm_pkg::LIST_W-1:0]  list_id;
  logic [dllm_pkg::NODE_W-1:0]  node;
  logic [dllm_pkg::NODE_W-1:0]  after_node;
  logic                         at_list_start;

  modport source (
    output valid, cmd, list_id, node, after_node, at_list_start,
    input  ready
  );

  modport sink (
    input  valid, cmd, list_id, node, after_node, at_list_start,
    output ready
  );
endinterface

`default_nettype wire

### rtl/dllm_out_if.sv
`default_nettype none

interface dllm_out_if;
  logic                         valid;
  logic                         ready;
  logic [dllm_pkg::NODE_W-1:0]  result_node;
  logic                         result_none;

  modport source (
    output valid, result_node, result_none,
    input  ready
  );

  modport sink (
    input  valid, result_node, result_none,
    output ready
  );
endinterface

`default_nettype wire

### rtl/dllm_ram.sv
`default_nettype none

module dllm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/doubly_linked_list_manager.sv
`default_nettype none

// Doubly linked lists over a shared pool of NODES nodes, LISTS lists. A link
// value below NODES names a node, NODES+L names the sentinel of list L, and
// NODES+LISTS marks a detached node. Successor links and list heads live in
// one synchronous RAM, predecessor links and list tails in a second, so a
// sentinel is simply an extra RAM entry. Each command is a short sequence of
// reads and writes, one read and one write per RAM per cycle with a registered
// read, and an item is taken only while the sequencer is idle. Clear and
// rejected commands go straight to the done state; head/tail/succ/pred and
// rem_head on an empty list read, add_tail/add_head/insert_after read then
// link, remove unlinks then detaches, rem_head of a node reads, unlinks,
// detaches; the dependent read and one write port per RAM set each sequence.
// A result waiting in the output register holds the following item in its
// done state, so the input stalls until the waiting result is taken.
// List heads and tails read as empty from reset and after a clear through
// per-list valid flags, so no clearing pass runs after reset.
module doubly_linked_list_manager #(
  parameter int unsigned NODES = 64,
  parameter int unsigned LISTS = 4
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dllm_in_if.sink     in_i,
  dllm_out_if.source  out_o
);

  localparam int unsigned DEPTH = NODES + LISTS;
  localparam int unsigned LW    = $clog2(DEPTH + 1);
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LIW   = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam logic [LW-1:0] DETACHED = LW'(DEPTH);

  // link value classes
  function automatic logic is_node(input logic [LW-1:0] v);
    return 32'(v) < NODES;
  endfunction

  function automatic logic is_mem(input logic [LW-1:0] v);
    return 32'(v) < DEPTH;
  endfunction

  function automatic logic is_sent(input logic [LW-1:0] v);
    return (32'(v) >= NODES) && (32'(v) < DEPTH);
  endfunction

  function automatic logic [LIW-1:0] sent_idx(input logic [LW-1:0] v);
    return LIW'(32'(v) - NODES);
  endfunction

  dllm_pkg::state_e state_q, state_d;
  dllm_pkg::cmd_e   cmd_q, cmd_d, in_cmd;

  logic [LW-1:0] n_q, n_d, s_q, s_d, l_q, l_d, tmp_q, tmp_d;
  logic [LW-1:0] rd_addr_q, rd_addr_d;
  logic [dllm_pkg::NODE_W-1:0] res_q, res_d, out_node_q;
  logic res_none_q, res_none_d, out_none_q, out_valid_q;
  logic [LISTS-1:0] nvld_q, pvld_q;

  logic in_acc, lok, nok, aok, in_go, out_free, clr_en;
  logic [LW-1:0] n_in, s_in, l_in;
  logic [LIW-1:0] clr_idx, rd_idx;
  logic rd_sent;
  logic [LW-1:0] n_rdata, p_rdata, rn, rp;

  logic          n_we, p_we;
  logic [LW-1:0] n_waddr, n_wdata, p_waddr, p_wdata;

  // input decode
  assign in_i.ready = (state_q == dllm_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_cmd     = dllm_pkg::cmd_e'(in_i.cmd);
  assign lok        = 32'(in_i.list_id) < LISTS;
  assign nok        = 32'(in_i.node) < NODES;
  assign aok        = 32'(in_i.after_node) < NODES;
  assign n_in       = LW'(in_i.node);
  assign s_in       = LW'(NODES + 32'(in_i.list_id));
  assign l_in       = in_i.at_list_start ? s_in : LW'(in_i.after_node);
  assign clr_idx    = LIW'(in_i.list_id);
  assign out_free   = !out_valid_q || out_o.ready;

  // whether the command touches the link memories at all
  always_comb begin
    case (in_cmd)
      dllm_pkg::CMD_ADD_TAIL,
      dllm_pkg::CMD_ADD_HEAD: in_go = lok && nok;
      dllm_pkg::CMD_INSERT:   in_go = nok && (in_i.at_list_start ? lok : aok);
      dllm_pkg::CMD_REM_HEAD,
      dllm_pkg::CMD_HEAD,
      dllm_pkg::CMD_TAIL:     in_go = lok;
      dllm_pkg::CMD_REMOVE,
      dllm_pkg::CMD_SUCC,
      dllm_pkg::CMD_PRED:     in_go = nok;
      default:                in_go = 1'b0;
    endcase
  end

  // read data, with untouched sentinels reading as an empty list
  assign rd_sent = is_sent(rd_addr_q);
  assign rd_idx  = sent_idx(rd_addr_q);
  assign rn = (rd_sent && !nvld_q[rd_idx]) ? rd_addr_q : n_rdata;
  assign rp = (rd_sent && !pvld_q[rd_idx]) ? rd_addr_q : p_rdata;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dllm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_go) begin
            state_d = dllm_pkg::ST_DONE;
          end else if (in_cmd == dllm_pkg::CMD_REMOVE) begin
            state_d = dllm_pkg::ST_UNLINK;
          end else begin
            state_d = dllm_pkg::ST_READ;
          end
        end
      end
      dllm_pkg::ST_READ: begin
        case (cmd_q)
          dllm_pkg::CMD_ADD_TAIL,
          dllm_pkg::CMD_ADD_HEAD,
          dllm_pkg::CMD_INSERT:   state_d = dllm_pkg::ST_LINK;
          dllm_pkg::CMD_REM_HEAD: state_d = is_node(rn) ? dllm_pkg::ST_UNLINK
                                                        : dllm_pkg::ST_DONE;
          default:                state_d = dllm_pkg::ST_DONE;
        endcase
      end
      dllm_pkg::ST_LINK:   state_d = dllm_pkg::ST_DONE;
      dllm_pkg::ST_UNLINK: state_d = dllm_pkg::ST_DETACH;
      dllm_pkg::ST_DETACH: state_d = dllm_pkg::ST_DONE;
      dllm_pkg::ST_DONE:   state_d = out_free ? dllm_pkg::ST_IDLE : dllm_pkg::ST_DONE;
      default:             state_d = dllm_pkg::ST_IDLE;
    endcase
  end

  // memory accesses and working registers
  always_comb begin
    n_we       = 1'b0;
    n_waddr    = n_q;
    n_wdata    = n_q;
    p_we       = 1'b0;
    p_waddr    = n_q;
    p_wdata    = n_q;
    rd_addr_d  = rd_addr_q;
    clr_en     = 1'b0;
    cmd_d      = cmd_q;
    n_d        = n_q;
    s_d        = s_q;
    l_d        = l_q;
    tmp_d      = tmp_q;
    res_d      = res_q;
    res_none_d = res_none_q;
    case (state_q)
      dllm_pkg::ST_IDLE: begin
        // first read goes out while the item is taken
        case (in_cmd)
          dllm_pkg::CMD_INSERT: rd_addr_d = l_in;
          dllm_pkg::CMD_REMOVE,
          dllm_pkg::CMD_SUCC,
          dllm_pkg::CMD_PRED:   rd_addr_d = n_in;
          default:              rd_addr_d = s_in;
        endcase
        if (in_acc) begin
          cmd_d      = in_cmd;
          n_d        = n_in;
          s_d        = s_in;
          l_d        = l_in;
          res_d      = '0;
          res_none_d = 1'b1;
          clr_en     = (in_cmd == dllm_pkg::CMD_CLEAR) && lok;
        end
      end
      dllm_pkg::ST_READ: begin
        case (cmd_q)
          dllm_pkg::CMD_ADD_TAIL: begin
            tmp_d   = rp;
            n_we    = 1'b1;
            n_wdata = s_q;
            p_we    = 1'b1;
            p_wdata = rp;
          end
          dllm_pkg::CMD_ADD_HEAD: begin
            tmp_d   = rn;
            n_we    = 1'b1;
            n_wdata = rn;
            p_we    = 1'b1;
            p_wdata = s_q;
          end
          dllm_pkg::CMD_INSERT: begin
            tmp_d   = rn;
            n_we    = 1'b1;
            n_wdata = rn;
            p_we    = 1'b1;
            p_wdata = l_q;
          end
          dllm_pkg::CMD_REM_HEAD: begin
            // head node becomes the node to unlink
            n_d       = rn;
            rd_addr_d = rn;
          end
          dllm_pkg::CMD_HEAD,
          dllm_pkg::CMD_SUCC: begin
            if (is_node(rn)) begin
              res_d      = dllm_pkg::NODE_W'(rn);
              res_none_d = 1'b0;
            end
          end
          dllm_pkg::CMD_TAIL,
          dllm_pkg::CMD_PRED: begin
            if (is_node(rp)) begin
              res_d      = dllm_pkg::NODE_W'(rp);
              res_none_d = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      dllm_pkg::ST_LINK: begin
        n_we    = 1'b1;
        p_we    = 1'b1;
        n_wdata = n_q;
        p_wdata = n_q;
        case (cmd_q)
          dllm_pkg::CMD_ADD_TAIL: begin
            n_waddr = tmp_q;
            p_waddr = s_q;
          end
          dllm_pkg::CMD_ADD_HEAD: begin
            n_waddr = s_q;
            p_waddr = tmp_q;
          end
          default: begin
            // insert after self leaves the node pointing at itself
            n_waddr = l_q;
            p_waddr = (l_q == n_q) ? n_q : tmp_q;
          end
        endcase
      end
      dllm_pkg::ST_UNLINK: begin
        // neighbours point past the node
        p_we    = 1'b1;
        p_waddr = rn;
        p_wdata = rp;
        n_we    = 1'b1;
        n_waddr = rp;
        n_wdata = rn;
      end
      dllm_pkg::ST_DETACH: begin
        n_we       = 1'b1;
        n_wdata    = DETACHED;
        p_we       = 1'b1;
        p_wdata    = DETACHED;
        res_d      = dllm_pkg::NODE_W'(n_q);
        res_none_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // link memories: successor / list head, predecessor / list tail
  dllm_ram #(
    .WIDTH (LW),
    .DEPTH (DEPTH)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (n_we && is_mem(n_waddr)),
    .waddr_i (AW'(n_waddr)),
    .wdata_i (n_wdata),
    .raddr_i (AW'(rd_addr_d)),
    .rdata_o (n_rdata)
  );

  dllm_ram #(
    .WIDTH (LW),
    .DEPTH (DEPTH)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (p_we && is_mem(p_waddr)),
    .waddr_i (AW'(p_waddr)),
    .wdata_i (p_wdata),
    .raddr_i (AW'(rd_addr_d)),
    .rdata_o (p_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dllm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      nvld_q      <= '0;
      pvld_q      <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == dllm_pkg::ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.valid && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (clr_en) begin
        nvld_q[clr_idx] <= 1'b0;
        pvld_q[clr_idx] <= 1'b0;
      end
      if (n_we && is_sent(n_waddr)) begin
        nvld_q[sent_idx(n_waddr)] <= 1'b1;
      end
      if (p_we && is_sent(p_waddr)) begin
        pvld_q[sent_idx(p_waddr)] <= 1'b1;
      end
    end
  end

  // working registers and output item
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    n_q        <= n_d;
    s_q        <= s_d;
    l_q        <= l_d;
    tmp_q      <= tmp_d;
    res_q      <= res_d;
    res_none_q <= res_none_d;
    rd_addr_q  <= rd_addr_d;
    if ((state_q == dllm_pkg::ST_DONE) && out_free) begin
      out_node_q <= res_q;
      out_none_q <= res_none_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_node = out_node_q;
  assign out_o.result_none = out_none_q;

  // reads that return data always hit a real RAM entry
  a_rd_in_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dllm_pkg::ST_READ || state_q == dllm_pkg::ST_UNLINK)
      |-> is_mem(rd_addr_q))
    else $error("link read outside memory");

  // an accepted item always leaves idle
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != dllm_pkg::ST_IDLE))
    else $error("sequencer idle after accept");

  // an unlinked node is the one returned
  a_detach_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dllm_pkg::ST_DETACH)
      |=> (state_q == dllm_pkg::ST_DONE) && !res_none_q
          && (res_q == dllm_pkg::NODE_W'($past(n_q))))
    else $error("detached node not returned");

  // results are only issued from the done state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == dllm_pkg::ST_DONE))
    else $error("result issued outside done state");

  // a none result carries a zero node
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dllm_pkg::ST_DONE && res_none_q) |-> (res_q == '0))
    else $error("none result with nonzero node");

endmodule

`default_nettype wire
